@@ hw/rtl/rlpm_pkg.sv @@
// ----------------------------------------------------------------------------
// rlpm_pkg
// Types, codes and compare helpers shared by the IPv4 LPM route table.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpm_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_PURGE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MASK  = 3'd1;
    localparam logic [2:0] ST_ZERO_PFX  = 3'd2;
    localparam logic [2:0] ST_HOST_BITS = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] address;
        logic [31:0] prefix_mask;
        logic [31:0] gateway_in;
        logic [7:0]  port_in;
        logic [7:0]  admin_dist_in;
        logic [15:0] metric_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [31:0] next_hop;
        logic [7:0]  out_port;
        logic [6:0]  removed_count;
        logic [6:0]  route_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [7:0]  port;
        logic [7:0]  admin_dist;
        logic [15:0] metric;
    } route_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_CHK,
        S_START,
        S_SCAN,
        S_DONE
    } state_t;

    // new route a goes ahead of stored route b
    function automatic logic precedes(route_t a, route_t b, logic use_ad);
        logic r;
        if (a.mask != b.mask)
            r = a.mask > b.mask;
        else if (a.prefix != b.prefix)
            r = a.prefix < b.prefix;
        else if (use_ad && (a.admin_dist != b.admin_dist))
            r = a.admin_dist < b.admin_dist;
        else
            r = a.metric < b.metric;
        return r;
    endfunction

    function automatic route_t to_route(req_t q);
        route_t r;
        r.prefix     = q.address;
        r.mask       = q.prefix_mask;
        r.gateway    = q.gateway_in;
        r.port       = q.port_in;
        r.admin_dist = q.admin_dist_in;
        r.metric     = q.metric_in;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ipv4_route_table_lpm_top.sv @@
// ----------------------------------------------------------------------------
// ipv4_route_table_lpm_top
// IPv4 unicast route table kept sorted for longest-prefix-match lookup.
//
//   channel   signals                        direction  handshake
//   request   start, busy, req               in         start && !busy
//   result    done, result                   out        done, one cycle
//   config    cfg_valid, cfg_ready, cfg_data in         cfg_valid && cfg_ready
//
// Each item walks the entry memory once at one entry per cycle, the
// single read port of the store setting the pace; a default-route add
// to a non-empty table first reads the last entry. A lookup ends at
// its first match; a rejected add does not walk the memory.
// Reset empties the table and sets use_admin_dist to 1; no clearing pass.
// The result cannot be stalled; busy stays high through the done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_route_table_lpm_top
    import rlpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      result,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);

    logic          use_ad_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    route_t        wr_data;
    logic [IW-1:0] rd_addr;
    route_t        rd_data;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            use_ad_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            use_ad_reg <= cfg_data;
    end

    rlpm_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req           (req),
        .use_admin_dist(use_ad_reg),
        .busy          (busy),
        .done          (done),
        .result        (result),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    rlpm_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rlpm_mem.sv @@
// ----------------------------------------------------------------------------
// rlpm_mem
// Route entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpm_mem
    import rlpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire route_t        wr_data,
    input  wire logic [IW-1:0] rd_addr,
    output route_t             rd_data
);

    route_t mem [TABLE_DEPTH];
    route_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rlpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlpm_ctrl
// Request sequencer: validates adds, then walks the sorted store once,
// reading entry i+1 while writing entry i or below.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpm_ctrl
    import rlpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    localparam int IW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire req_t          req,
    input  wire logic          use_admin_dist,
    output logic               busy,
    output logic               done,
    output rsp_t               result,
    output logic               wr_en,
    output logic [IW-1:0]      wr_addr,
    output route_t             wr_data,
    output logic [IW-1:0]      rd_addr,
    input  wire route_t        rd_data
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    function automatic logic [IW-1:0] to_addr(logic [CW-1:0] v);
        return (v < DEPTH_C) ? v[IW-1:0] : '0;
    endfunction

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    route_t        carry_reg, carry_next;
    logic          found_reg, found_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [2:0]    status_reg, status_next;
    logic          hit_reg, hit_next;
    logic [31:0]   nh_reg, nh_next;
    logic [7:0]    oport_reg, oport_next;
    logic [CW-1:0] rmv_reg, rmv_next;

    logic   accept;
    logic   at_end;
    route_t new_rt;
    logic   prec;
    logic   exact;
    logic   lk_match;
    logic [31:0] inv_mask;
    logic   bad_mask;
    logic   zero_pfx;
    logic   host_bits;
    logic   add_ok;

    assign accept    = start && (state_reg == S_IDLE);
    assign at_end    = idx_reg == lim_reg;
    assign new_rt    = to_route(req_reg);
    assign prec      = precedes(new_rt, rd_data, use_admin_dist);
    assign exact     = rd_data == new_rt;
    assign lk_match  = ((req_reg.address ^ rd_data.prefix) & rd_data.mask) == 32'd0;
    assign inv_mask  = ~req.prefix_mask;
    assign bad_mask  = (inv_mask & (inv_mask + 32'd1)) != 32'd0;
    assign zero_pfx  = (req.prefix_mask != 32'd0) && ((req.address & req.prefix_mask) == 32'd0);
    assign host_bits = (req.address & inv_mask) != 32'd0;
    assign add_ok    = !bad_mask && !zero_pfx && !host_bits;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type != REQ_ADD)
                        state_next = S_START;
                    else if (!add_ok)
                        state_next = S_DONE;
                    else if ((req.prefix_mask == 32'd0) && (total_reg != '0))
                        state_next = S_PRE;
                    else if (total_reg >= DEPTH_C)
                        state_next = S_DONE;
                    else
                        state_next = S_START;
                end
            end
            S_PRE:
                state_next = S_CHK;
            S_CHK:
            begin
                if ((rd_data.mask != 32'd0) && (total_reg >= DEPTH_C))
                    state_next = S_DONE;
                else
                    state_next = S_START;
            end
            S_START:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (at_end)
                    state_next = S_DONE;
                else if ((req_reg.req_type == REQ_LOOKUP) && lk_match)
                    state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = state_reg != S_IDLE;
        done = state_reg == S_DONE;
        result.status        = status_reg;
        result.hit           = hit_reg;
        result.next_hop      = nh_reg;
        result.out_port      = oport_reg;
        result.removed_count = 7'(rmv_reg);
        result.route_count   = 7'(total_reg);
    end

    // datapath and store access
    always_comb
    begin
        req_next    = req_reg;
        carry_next  = carry_reg;
        found_next  = found_reg;
        total_next  = total_reg;
        lim_next    = lim_reg;
        idx_next    = idx_reg;
        wp_next     = wp_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        nh_next     = nh_reg;
        oport_next  = oport_reg;
        rmv_next    = rmv_reg;
        wr_en       = 1'b0;
        wr_addr     = to_addr(idx_reg);
        wr_data     = rd_data;
        rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req;
                    found_next  = 1'b0;
                    lim_next    = total_reg;
                    idx_next    = '0;
                    wp_next     = '0;
                    hit_next    = 1'b0;
                    nh_next     = '0;
                    oport_next  = '0;
                    rmv_next    = '0;
                    status_next = ST_OK;
                    if (req.req_type == REQ_ADD)
                    begin
                        if (bad_mask)
                            status_next = ST_BAD_MASK;
                        else if (zero_pfx)
                            status_next = ST_ZERO_PFX;
                        else if (host_bits)
                            status_next = ST_HOST_BITS;
                        else if (!((req.prefix_mask == 32'd0) && (total_reg != '0))
                                 && (total_reg >= DEPTH_C))
                            status_next = ST_FULL;
                    end
                end
            end
            S_PRE:
            begin
                rd_addr = to_addr(total_reg - ONE_C);
            end
            S_CHK:
            begin
                if (rd_data.mask == 32'd0)
                begin
                    rmv_next = ONE_C;
                    lim_next = total_reg - ONE_C;
                end
                else if (total_reg >= DEPTH_C)
                begin
                    status_next = ST_FULL;
                end
            end
            S_START:
            begin
                rd_addr = '0;
            end
            S_SCAN:
            begin
                rd_addr  = to_addr(idx_reg + ONE_C);
                idx_next = idx_reg + ONE_C;
                if (at_end)
                begin
                    unique case (req_reg.req_type)
                        REQ_ADD:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = to_addr(lim_reg);
                            wr_data    = found_reg ? carry_reg : new_rt;
                            total_next = lim_reg + ONE_C;
                        end
                        REQ_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                total_next = lim_reg - ONE_C;
                                hit_next   = 1'b1;
                                rmv_next   = ONE_C;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        REQ_PURGE:
                        begin
                            total_next = wp_reg;
                            rmv_next   = lim_reg - wp_reg;
                            hit_next   = lim_reg != wp_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    unique case (req_reg.req_type)
                        REQ_ADD:
                        begin
                            if (found_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_data    = carry_reg;
                                carry_next = rd_data;
                            end
                            else if (prec)
                            begin
                                wr_en      = 1'b1;
                                wr_data    = new_rt;
                                carry_next = rd_data;
                                found_next = 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = to_addr(idx_reg - ONE_C);
                            end
                            else if (exact)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            if (lk_match)
                            begin
                                hit_next   = 1'b1;
                                nh_next    = rd_data.gateway;
                                oport_next = rd_data.port;
                            end
                        end
                        REQ_PURGE:
                        begin
                            if (rd_data.port != req_reg.port_in)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = to_addr(wp_reg);
                                wp_next = wp_reg + ONE_C;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        carry_reg  <= carry_next;
        found_reg  <= found_next;
        lim_reg    <= lim_next;
        idx_reg    <= idx_next;
        wp_reg     <= wp_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        nh_reg     <= nh_next;
        oport_reg  <= oport_next;
        rmv_reg    <= rmv_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rlpm_checker.sv @@
// ----------------------------------------------------------------------------
// rlpm_checker
// Port-level checks for the route table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpm_checker
    import rlpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t result
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.route_count <= 7'(TABLE_DEPTH)))
        else $error("route count beyond table depth");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (result.status == ST_OK))
        else $error("hit with error status");

endmodule

bind ipv4_route_table_lpm_top rlpm_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_rlpm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

`default_nettype wire
